@@ design/hilbert_point_to_index_top_defines.svh @@
// assertion macros shared by the hilbert point to index design
`ifndef HILBERT_POINT_TO_INDEX_TOP_DEFINES_SVH
`define HILBERT_POINT_TO_INDEX_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define HPI_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define HPI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/hpi_pkg.sv @@
// shared constants and types for the hilbert point to index converter
package hpi_pkg;

    // default curve geometry
    localparam int DEF_MAX_AXES = 3;
    localparam int DEF_MAX_BITS = 21;

    // bit levels handled by one undo pipeline stage
    localparam int LEVELS_PER_STAGE = 2;

    // configuration port
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 5;

    localparam logic [CFG_INDEX_W-1:0] CFG_CURVE_BITS  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ACTIVE_AXES = 1'b1;

    localparam logic [4:0] RST_CURVE_BITS  = 5'd21;
    localparam logic [1:0] RST_ACTIVE_AXES = 2'd3;

    // effective (clamped) configuration handed to the stages
    typedef struct packed {
        logic [4:0] bits;
        logic [1:0] axes;
    } hpi_cfg_t;

endpackage

@@ design/hpi_undo_stage.sv @@
// one pipeline stage of the inverse undo pass, two bit levels per stage
module hpi_undo_stage
    import hpi_pkg::*;
#(
    parameter int MAX_AXES  = DEF_MAX_AXES,
    parameter int MAX_BITS  = DEF_MAX_BITS,
    parameter int STAGE_IDX = 0
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  hpi_cfg_t                            cfg,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [MAX_AXES-1:0][MAX_BITS-1:0]   in_coord,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [MAX_AXES-1:0][MAX_BITS-1:0]   out_coord
);

    // highest bit level this stage works on
    localparam int LEVEL_HI = MAX_BITS - 1 - LEVELS_PER_STAGE * STAGE_IDX;

    logic                              valid_reg;
    logic                              valid_next;
    logic [MAX_AXES-1:0][MAX_BITS-1:0] coord_reg;
    logic [MAX_AXES-1:0][MAX_BITS-1:0] coord_next;

    always_comb
    begin
        logic [MAX_AXES-1:0][MAX_BITS-1:0] c;
        logic [MAX_BITS-1:0]               low_mask;
        logic [MAX_BITS-1:0]               lvl_mask;
        logic [MAX_BITS-1:0]               swap;
        int                                lvl;
        c        = in_coord;
        low_mask = '0;
        lvl_mask = '0;
        swap     = '0;
        lvl      = 0;
        for (int j = 0; j < LEVELS_PER_STAGE; j++)
        begin
            lvl = LEVEL_HI - j;
            if (lvl >= 1 && lvl < int'(cfg.bits))
            begin
                for (int k = 0; k < MAX_BITS; k++)
                begin
                    low_mask[k] = (k < lvl);
                    lvl_mask[k] = (k == lvl);
                end
                for (int i = 0; i < MAX_AXES; i++)
                begin
                    if (i < int'(cfg.axes))
                    begin
                        if (|(c[i] & lvl_mask))
                        begin
                            // invert low bits of axis 0
                            c[0] = c[0] ^ low_mask;
                        end
                        else
                        begin
                            // exchange low bits of axis 0 and axis i
                            swap = (c[0] ^ c[i]) & low_mask;
                            c[0] = c[0] ^ swap;
                            c[i] = c[i] ^ swap;
                        end
                    end
                end
            end
        end
        coord_next = c;
    end

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            coord_reg <= coord_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_coord = coord_reg;

endmodule

@@ design/hpi_gray_stage.sv @@
// gray encode, parity correction and bit interleave into the output register
module hpi_gray_stage
    import hpi_pkg::*;
#(
    parameter int MAX_AXES = DEF_MAX_AXES,
    parameter int MAX_BITS = DEF_MAX_BITS
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  hpi_cfg_t                            cfg,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [MAX_AXES-1:0][MAX_BITS-1:0]   in_coord,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [MAX_AXES*MAX_BITS-1:0]        out_index
);

    logic                         valid_reg;
    logic                         valid_next;
    logic [MAX_AXES*MAX_BITS-1:0] index_reg;
    logic [MAX_AXES*MAX_BITS-1:0] index_next;

    always_comb
    begin
        logic [MAX_AXES-1:0][MAX_BITS-1:0] c;
        logic [MAX_BITS-1:0]               last;
        logic [MAX_BITS-1:0]               fix;
        c    = in_coord;
        last = '0;
        fix  = '0;
        index_next = '0;
        for (int i = 1; i < MAX_AXES; i++)
        begin
            if (i < int'(cfg.axes))
            begin
                c[i] = c[i] ^ c[i-1];
            end
        end
        for (int i = 0; i < MAX_AXES; i++)
        begin
            if (i == int'(cfg.axes) - 1)
            begin
                last = c[i];
            end
        end
        // each correction bit is the parity of the last axis above it
        for (int k = 0; k < MAX_BITS; k++)
        begin
            for (int m = k + 1; m < MAX_BITS; m++)
            begin
                fix[k] = fix[k] ^ last[m];
            end
        end
        for (int i = 0; i < MAX_AXES; i++)
        begin
            if (i < int'(cfg.axes))
            begin
                c[i] = c[i] ^ fix;
            end
        end
        // level 0 first, axis 0 in the top place of each group
        for (int nn = 1; nn <= MAX_AXES; nn++)
        begin
            if (nn == int'(cfg.axes))
            begin
                for (int lvl = 0; lvl < MAX_BITS; lvl++)
                begin
                    for (int i = 0; i < nn; i++)
                    begin
                        index_next[lvl*nn + nn - 1 - i] = c[i][lvl];
                    end
                end
            end
        end
    end

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            index_reg <= index_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_index = index_reg;

endmodule

@@ design/hilbert_point_to_index_top.sv @@
// top level of the hilbert point to index converter
//
//   channel  | handshake            | payload
//   ---------+----------------------+------------------------------------------
//   in       | in_valid / in_stall  | axis0_coord, axis1_coord, axis2_coord
//   out      | out_valid / out_stall| hilbert_index
//   config   | cfg_write            | cfg_index, cfg_data (no wait, no read-back)
//
// one request accepted per cycle while in_stall is low; each point passes through the undo
//   stages in order and then through the gray/interleave stage
// the undo pass handles two bit levels per stage, so MAX_BITS sets the depth
// every stage has its own valid bit; a stage loads whenever it is empty or the
//   one after it moves, so bubbles close up behind a stalled output
// out_stall holds the output register and the stages behind it, nothing is
//   dropped or repeated
// rst_n clears all valid bits and loads curve_bits = 21, active_axes = 3
module hilbert_point_to_index_top
    import hpi_pkg::*;
#(
    parameter int MAX_AXES = DEF_MAX_AXES,
    parameter int MAX_BITS = DEF_MAX_BITS
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    // configuration write port
    input  logic                         cfg_write,
    input  logic [CFG_INDEX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data,
    // point request
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [MAX_BITS-1:0]          axis0_coord,
    input  logic [MAX_BITS-1:0]          axis1_coord,
    input  logic [MAX_BITS-1:0]          axis2_coord,
    // index output
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [MAX_AXES*MAX_BITS-1:0] hilbert_index
);

`include "hilbert_point_to_index_top_defines.svh"

    // undo stages cover bit levels MAX_BITS-1 down to 1
    localparam int UNDO_RAW    = (MAX_BITS + LEVELS_PER_STAGE - 2) / LEVELS_PER_STAGE;
    localparam int UNDO_STAGES = (UNDO_RAW < 1) ? 1 : UNDO_RAW;

    // configuration registers
    logic [4:0] curve_bits_reg;
    logic [4:0] curve_bits_next;
    logic [1:0] active_axes_reg;
    logic [1:0] active_axes_next;
    hpi_cfg_t   cfg;

    // masked and zeroed point at the input port
    logic [MAX_AXES-1:0][MAX_BITS-1:0] masked_coord;

    // pipeline links, entry 0 is the input port side
    logic                              stg_valid [UNDO_STAGES+1];
    logic                              stg_ready [UNDO_STAGES+1];
    logic [MAX_AXES-1:0][MAX_BITS-1:0] stg_coord [UNDO_STAGES+1];

    always_comb
    begin
        curve_bits_next  = curve_bits_reg;
        active_axes_next = active_axes_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_CURVE_BITS:  curve_bits_next  = cfg_data;
                CFG_ACTIVE_AXES: active_axes_next = cfg_data[1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            curve_bits_reg  <= RST_CURVE_BITS;
            active_axes_reg <= RST_ACTIVE_AXES;
        end
        else
        begin
            curve_bits_reg  <= curve_bits_next;
            active_axes_reg <= active_axes_next;
        end
    end

    // clamp zero up to one and large values down to the build limits
    always_comb
    begin
        if (curve_bits_reg == 5'd0)
        begin
            cfg.bits = 5'd1;
        end
        else if (int'(curve_bits_reg) > MAX_BITS)
        begin
            cfg.bits = 5'(MAX_BITS);
        end
        else
        begin
            cfg.bits = curve_bits_reg;
        end
        if (active_axes_reg == 2'd0)
        begin
            cfg.axes = 2'd1;
        end
        else if (int'(active_axes_reg) > MAX_AXES)
        begin
            cfg.axes = 2'(MAX_AXES);
        end
        else
        begin
            cfg.axes = active_axes_reg;
        end
    end

    // mask coordinate bits above the curve order, zero unused axes
    always_comb
    begin
        logic [MAX_BITS-1:0] bit_mask;
        logic [MAX_BITS-1:0] raw;
        bit_mask     = '0;
        raw          = '0;
        masked_coord = '0;
        for (int k = 0; k < MAX_BITS; k++)
        begin
            bit_mask[k] = (k < int'(cfg.bits));
        end
        for (int a = 0; a < MAX_AXES; a++)
        begin
            case (a)
                0:       raw = axis0_coord;
                1:       raw = axis1_coord;
                default: raw = axis2_coord;
            endcase
            masked_coord[a] = (a < int'(cfg.axes)) ? (raw & bit_mask) : '0;
        end
    end

    assign stg_coord[0] = masked_coord;
    assign stg_valid[0] = in_valid;
    assign in_stall     = !stg_ready[0];

    genvar s;
    generate
        for (s = 0; s < UNDO_STAGES; s++)
        begin : g_undo
            hpi_undo_stage #(
                .MAX_AXES  (MAX_AXES),
                .MAX_BITS  (MAX_BITS),
                .STAGE_IDX (s)
            ) u_undo (
                .clk       (clk),
                .rst_n     (rst_n),
                .cfg       (cfg),
                .in_valid  (stg_valid[s]),
                .in_ready  (stg_ready[s]),
                .in_coord  (stg_coord[s]),
                .out_valid (stg_valid[s+1]),
                .out_ready (stg_ready[s+1]),
                .out_coord (stg_coord[s+1])
            );
        end
    endgenerate

    // gray encode and interleave, ends in the output register
    hpi_gray_stage #(
        .MAX_AXES (MAX_AXES),
        .MAX_BITS (MAX_BITS)
    ) u_gray (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (stg_valid[UNDO_STAGES]),
        .in_ready  (stg_ready[UNDO_STAGES]),
        .in_coord  (stg_coord[UNDO_STAGES]),
        .out_valid (out_valid),
        .out_ready (!out_stall),
        .out_index (hilbert_index)
    );

    // an empty output register means the whole ready chain is open
    `HPI_ASSERT_SAME(a_empty_out_accepts, !out_valid, !in_stall,
        "input stalled while output register empty")

    // an accepted point always lands in the first stage
    `HPI_ASSERT_NEXT(a_accept_fills_first, in_valid && !in_stall, stg_valid[1],
        "accepted point missing from first stage")

    // last undo stage holds its point while the gray stage is blocked
    `HPI_ASSERT_NEXT(a_undo_hold,
        stg_valid[UNDO_STAGES] && !stg_ready[UNDO_STAGES],
        stg_valid[UNDO_STAGES] && $stable(stg_coord[UNDO_STAGES]),
        "last undo stage lost or changed a blocked point")

endmodule

@@ tb/sv/tb.sv @@
// testbench for the hilbert point to index converter: predictor, driver and checker
`timescale 1ns / 1ps

module tb;
    import hpi_pkg::*;

    localparam int CW = DEF_MAX_BITS;               // coordinate width
    localparam int IW = DEF_MAX_AXES * DEF_MAX_BITS; // index width
    localparam int HOLD_CYCLES = 60;                // long output hold, well past pipeline depth
    localparam int NUM_SETTINGS = 14;

    typedef struct packed {
        logic [CW-1:0] axis0;
        logic [CW-1:0] axis1;
        logic [CW-1:0] axis2;
    } point_t;

    // clock, reset and block ports
    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_CURVE_BITS;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [CW-1:0]          axis0_coord = '0;
    logic [CW-1:0]          axis1_coord = '0;
    logic [CW-1:0]          axis2_coord = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b1;
    logic [IW-1:0]          hilbert_index;

    // register copies as last written (raw, unclamped)
    logic [4:0] curve_bits_set = RST_CURVE_BITS;
    logic [1:0] axes_set = RST_ACTIVE_AXES;

    // points waiting to be sent, and indexes waiting to come back
    point_t        pending_q[$];
    logic [IW-1:0] index_q[$];

    // idling controls, set per phase by the sequencer
    bit idle_on = 1'b1;
    int gap_pct = 25;
    int stall_pct = 25;
    int hold_reqs = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int gap_left = 0;
    int stall_left = 0;

    int errors = 0;
    int n_sent = 0;
    int n_checked = 0;
    logic req_taken = 1'b0;

    hilbert_point_to_index_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .axis0_coord  (axis0_coord),
        .axis1_coord  (axis1_coord),
        .axis2_coord  (axis2_coord),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .hilbert_index(hilbert_index)
    );

    // 20 ns period
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // expected curve position of one point under the current register values
    function automatic logic [IW-1:0] hilbert_of(input point_t pt);
        int unsigned nbits;
        int unsigned naxes;
        int unsigned topq;
        int unsigned q;
        int unsigned t;
        int unsigned lvl;
        int unsigned i;
        int unsigned pos;
        logic [31:0] msk;
        logic [31:0] c [3];
        logic [IW-1:0] idx;
        // zero clamps up to one, oversize clamps down to the maximum
        nbits = (curve_bits_set == 0) ? 1 : (curve_bits_set > CW) ? CW : curve_bits_set;
        naxes = (axes_set == 0) ? 1 : axes_set;
        msk = (32'd1 << nbits) - 32'd1;
        topq = 32'd1 << (nbits - 1);
        // bits above the curve order and unused axes drop out here
        c[0] = {11'd0, pt.axis0} & msk;
        c[1] = (naxes > 1) ? ({11'd0, pt.axis1} & msk) : 32'd0;
        c[2] = (naxes > 2) ? ({11'd0, pt.axis2} & msk) : 32'd0;
        // undo pass, top level down to level 1
        for (q = topq; q > 1; q = q >> 1)
        begin
            for (i = 0; i < naxes; i++)
            begin
                if ((c[i] & q) != 0)
                begin
                    c[0] ^= q - 1;
                end
                else
                begin
                    t = (c[0] ^ c[i]) & (q - 1);
                    c[0] ^= t;
                    c[i] ^= t;
                end
            end
        end
        // gray encode plus parity fix from the last axis
        for (i = 1; i < naxes; i++)
            c[i] ^= c[i - 1];
        t = 0;
        for (q = topq; q > 1; q = q >> 1)
            if ((c[naxes - 1] & q) != 0)
                t ^= q - 1;
        for (i = 0; i < naxes; i++)
            c[i] ^= t;
        // interleave, level 0 first, axis 0 highest within each group
        idx = '0;
        pos = 0;
        for (lvl = 0; lvl < nbits; lvl++)
        begin
            for (i = naxes; i > 0; i--)
            begin
                idx[pos] = c[i - 1][lvl];
                pos++;
            end
        end
        return idx;
    endfunction

    // random point: mostly full-width noise, some small values, corners and repeats
    function automatic point_t rand_point();
        point_t pt;
        int unsigned kind;
        int unsigned w;
        kind = $urandom_range(0, 99);
        pt.axis0 = CW'($urandom);
        pt.axis1 = CW'($urandom);
        pt.axis2 = CW'($urandom);
        if (kind < 20)
        begin
            // values that fit a short curve order
            w = $urandom_range(1, CW);
            pt.axis0 = pt.axis0 & ((21'd1 << w) - 21'd1);
            pt.axis1 = pt.axis1 & ((21'd1 << w) - 21'd1);
            pt.axis2 = pt.axis2 & ((21'd1 << w) - 21'd1);
        end
        else if (kind < 30)
        begin
            // all-zero or all-one axes, or one bit alone
            pt.axis0 = $urandom_range(0, 1) ? '1 : '0;
            pt.axis1 = $urandom_range(0, 1) ? '0 : (21'd1 << $urandom_range(0, CW - 1));
            pt.axis2 = $urandom_range(0, 1) ? '1 : (21'd1 << $urandom_range(0, CW - 1));
        end
        else if (kind < 40)
        begin
            // equal axes walk the diagonal
            pt.axis1 = pt.axis0;
            pt.axis2 = $urandom_range(0, 1) ? pt.axis0 : ~pt.axis0;
        end
        return pt;
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        errors++;
    endtask

    // register write between phases, only while nothing is in flight
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_write <= 1'b0;
        if (idx == CFG_CURVE_BITS)
            curve_bits_set = val;
        else
            axes_set = val[1:0];
    endtask

    // wait until every queued point went in and every index came back
    task automatic drain();
        do
            @(negedge clk);
        while (pending_q.size() != 0 || in_valid || index_q.size() != 0);
        // every request yields an index, so the extra wait below is only a margin
        repeat (4) @(negedge clk);
    endtask

    // request driver: inputs move on the falling edge, a stalled request holds still
    always @(negedge clk)
    begin
        point_t nxt;
        logic   drive;
        nxt = '0;
        drive = 1'b0;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || req_taken)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
            end
            else if (pending_q.size() == 0)
            begin
                drive = 1'b0;
            end
            else if (idle_on && $urandom_range(0, 99) < gap_pct)
            begin
                // this cycle opens a random gap in the requests
                gap_left = $urandom_range(0, 4);
            end
            else
            begin
                nxt = pending_q.pop_front();
                drive = 1'b1;
            end
            in_valid <= drive;
            if (drive)
            begin
                axis0_coord <= nxt.axis0;
                axis1_coord <= nxt.axis1;
                axis2_coord <= nxt.axis2;
            end
        end
    end

    // output stall: short random bursts, plus the long hold when asked for
    always @(negedge clk)
    begin
        logic hold;
        if (hold_seen != hold_reqs)
        begin
            hold_seen = hold_reqs;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            hold = 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            hold = 1'b1;
        end
        else if (idle_on && $urandom_range(0, 99) < stall_pct)
        begin
            stall_left = $urandom_range(0, 4);
            hold = 1'b1;
        end
        else
        begin
            hold = 1'b0;
        end
        out_stall <= hold;
    end

    // rising edge: predict on each accepted point, check each accepted index
    always @(posedge clk)
    begin
        point_t      pt;
        logic [IW-1:0] want;
        req_taken <= in_valid && !in_stall;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                pt.axis0 = axis0_coord;
                pt.axis1 = axis1_coord;
                pt.axis2 = axis2_coord;
                index_q.push_back(hilbert_of(pt));
                n_sent++;
            end
            if (out_valid && !out_stall)
            begin
                if (index_q.size() == 0)
                begin
                    report_mismatch($sformatf("index 0x%016h with no request pending",
                                              hilbert_index));
                end
                else
                begin
                    want = index_q.pop_front();
                    if (hilbert_index !== want)
                        report_mismatch($sformatf("hilbert_index 0x%016h, predicted 0x%016h",
                                                  hilbert_index, want));
                    n_checked++;
                end
            end
        end
    end

    // register settings per phase: zero and oversize values, raw data with
    // upper bits set on the axis count, and the extremes of both
    logic [CFG_DATA_W-1:0] bits_list [NUM_SETTINGS] =
        '{5'd1, 5'd0, 5'd31, 5'd21, 5'd2, 5'd3, 5'd21, 5'd22, 5'd7, 5'd13, 5'd20, 5'd5,
          5'd1, 5'd16};
    logic [CFG_DATA_W-1:0] axes_list [NUM_SETTINGS] =
        '{5'd1, 5'd0, 5'd3, 5'd1, 5'd2, 5'd3, 5'd30, 5'd29, 5'd3, 5'd2, 5'd3, 5'd1,
          5'd3, 5'd31};

    // sequencer
    initial
    begin
        point_t pt;
        int     k;
        int     ph;
        // reset held low at start, released on a falling edge
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed points at the reset geometry
        pending_q.push_back('{21'd0, 21'd0, 21'd0});
        pending_q.push_back('{'1, '1, '1});
        pending_q.push_back('{'1, 21'd0, 21'd0});
        pending_q.push_back('{21'd0, '1, 21'd0});
        pending_q.push_back('{21'd0, 21'd0, '1});
        pending_q.push_back('{21'h155555, 21'h0AAAAA, 21'h155555});
        pending_q.push_back('{21'h0AAAAA, 21'h155555, 21'h0AAAAA});
        for (k = 0; k < CW; k += 5)
        begin
            pending_q.push_back('{21'd1 << k, 21'd0, 21'd0});
            pending_q.push_back('{21'd0, 21'd1 << k, 21'd0});
            pending_q.push_back('{21'd0, 21'd0, 21'd1 << k});
        end
        pending_q.push_back('{21'h100000, 21'h100000, 21'h100000});
        pending_q.push_back('{21'h0FFFFF, 21'h0FFFFF, 21'h0FFFFF});
        pending_q.push_back('{21'd1, 21'd2, 21'd3});
        for (k = 0; k < 150; k++)
            pending_q.push_back(rand_point());

        // long output hold while requests keep coming, so the input backs up
        wait (n_sent >= 40);
        hold_reqs++;
        drain();

        // one phase per register setting; every fourth phase runs without idling
        for (ph = 0; ph < NUM_SETTINGS; ph++)
        begin
            gap_pct = (ph % 4 == 3) ? 0 : 25;
            stall_pct = (ph % 4 == 3) ? 0 : 25;
            write_reg(CFG_CURVE_BITS, bits_list[ph]);
            write_reg(CFG_ACTIVE_AXES, axes_list[ph]);
            for (k = 0; k < 50; k++)
                pending_q.push_back(rand_point());
            drain();
        end

        // last part, full geometry, no idling on either side
        idle_on = 1'b0;
        write_reg(CFG_CURVE_BITS, 5'd21);
        write_reg(CFG_ACTIVE_AXES, 5'd3);
        for (k = 0; k < 75; k++)
            pending_q.push_back(rand_point());
        drain();

        // let anything stray surface past the pipeline depth
        repeat (DEF_MAX_BITS / LEVELS_PER_STAGE + 10) @(posedge clk);

        $display("checked %0d of %0d points over %0d register settings plus reset geometry,",
                 n_checked, n_sent, NUM_SETTINGS);
        $display("with clamped register values, random idling and one long output hold");
        if (errors == 0 && index_q.size() == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("%0d mismatches, %0d indexes never arrived", errors, index_q.size());
            $display("simulation failed");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #2000000;
        $display("timeout with %0d indexes outstanding", index_q.size());
        $display("simulation failed");
        $finish;
    end

endmodule
